// ===== src/tco_pkg.sv =====
`default_nettype none

package tco_pkg;

    // Fixed field widths of the request and response
    localparam int NAME_BITS   = 64;
    localparam int ADDR_BITS   = 32;
    localparam int TTL_BITS    = 32;
    localparam int TICK_BITS   = 32;
    localparam int SLOT_BITS   = 8;
    localparam int KIND_BITS   = 2;
    localparam int STATUS_BITS = 2;

    // Expired entries are swept whenever the tick counter is a multiple of this
    localparam int CLEAN_PERIOD = 60;
    localparam int PHASE_BITS   = $clog2(CLEAN_PERIOD);

    typedef logic [KIND_BITS-1:0]   kind_t;
    typedef logic [STATUS_BITS-1:0] status_t;

    // Request kinds
    localparam kind_t KIND_TICK   = 2'd0;
    localparam kind_t KIND_INSERT = 2'd1;
    localparam kind_t KIND_LOOKUP = 2'd2;

    // Response status codes
    localparam status_t ST_TICK   = 2'd0;
    localparam status_t ST_STORED = 2'd1;
    localparam status_t ST_HIT    = 2'd2;
    localparam status_t ST_MISS   = 2'd3;

    // Controller to datapath
    typedef struct packed {
        logic capture;   // latch the accepted request, advance the timer on a tick
        logic scan_run;  // step the entry scan
        logic write;     // write the chosen entry of an insert
        logic load_rsp;  // load the response register
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        kind_t kind;       // kind of the held request
        logic  clean_due;  // held tick landed on a sweep boundary
        logic  scan_last;  // last entry of the scan is being checked
    } stat_t;

endpackage

`default_nettype wire

// ===== src/tco_req_if.sv =====
`default_nettype none

interface tco_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [63:0] name_key;
    logic [31:0] ip_address;
    logic [31:0] ttl;

    modport source (output valid, output kind, output name_key, output ip_address,
                    output ttl, input ready);
    modport sink   (input valid, input kind, input name_key, input ip_address,
                    input ttl, output ready);
endinterface

`default_nettype wire

// ===== src/tco_rsp_if.sv =====
`default_nettype none

interface tco_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [7:0]  slot;
    logic [31:0] found_address;

    modport source (output valid, output status, output slot, output found_address,
                    input ready);
    modport sink   (input valid, input status, input slot, input found_address,
                     output ready);
endinterface

`default_nettype wire

// ===== src/tco_ram.sv =====
`default_nettype none

module tco_ram #(
    parameter int WIDTH = 160,
    parameter int DEPTH = 16
) (
    input  wire logic                                       clk,
    input  wire logic                                       wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                           wr_data,
    input  wire logic                                       rd_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                                rd_data
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];

    // One write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== src/tco_ctrl.sv =====
`default_nettype none

module tco_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           req_valid,
    output logic                req_ready,
    output logic                rsp_valid,
    input  wire logic           rsp_ready,
    output tco_pkg::cmd_t       cmd,
    input  wire tco_pkg::stat_t stat
);

    import tco_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN,
        S_WRITE,
        S_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   rsp_free;

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = out_valid_reg;
    assign rsp_free  = !out_valid_reg || rsp_ready;

    // Next state and commands
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        if (out_valid_reg && rsp_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (stat.kind == KIND_INSERT || stat.kind == KIND_LOOKUP || stat.clean_due)
                begin
                    state_next = S_SCAN;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_SCAN:
            begin
                cmd.scan_run = 1'b1;
                if (stat.scan_last)
                begin
                    state_next = (stat.kind == KIND_INSERT) ? S_WRITE : S_DONE;
                end
            end
            S_WRITE:
            begin
                cmd.write  = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                // wait for the response register to free up
                if (rsp_free)
                begin
                    cmd.load_rsp   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_rsp |=> out_valid_reg)
        else $error("response load did not raise valid");

    a_scan_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) && stat.scan_last |=> state_reg != S_SCAN)
        else $error("scan ran past the last entry");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("response dropped before it was taken");

endmodule

`default_nettype wire

// ===== src/tco_dp.sv =====
`default_nettype none

module tco_dp #(
    parameter int CACHE_ENTRIES = 16,
    parameter int KEY_BITS      = 64
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire tco_pkg::cmd_t                      cmd,
    output tco_pkg::stat_t                          stat,
    input  wire logic [tco_pkg::KIND_BITS-1:0]      req_kind,
    input  wire logic [tco_pkg::NAME_BITS-1:0]      req_name_key,
    input  wire logic [tco_pkg::ADDR_BITS-1:0]      req_ip_address,
    input  wire logic [tco_pkg::TTL_BITS-1:0]       req_ttl,
    output logic [tco_pkg::STATUS_BITS-1:0]         rsp_status,
    output logic [tco_pkg::SLOT_BITS-1:0]           rsp_slot,
    output logic [tco_pkg::ADDR_BITS-1:0]           rsp_found_address
);

    import tco_pkg::*;

    localparam int IW = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
    localparam int CW = $clog2(CACHE_ENTRIES + 1);
    // entry word: key | address | lifetime | stamp
    localparam int EW = KEY_BITS + ADDR_BITS + TTL_BITS + TICK_BITS;
    localparam int LIFE_LO = TICK_BITS;
    localparam int ADDR_LO = TICK_BITS + TTL_BITS;
    localparam int KEY_LO  = TICK_BITS + TTL_BITS + ADDR_BITS;

    // held request
    kind_t                  kind_reg, kind_next;
    logic [KEY_BITS-1:0]    key_reg, key_next;
    logic [ADDR_BITS-1:0]   ip_reg, ip_next;
    logic [TTL_BITS-1:0]    ttl_reg, ttl_next;

    // timer
    logic [TICK_BITS-1:0]   tick_reg, tick_next;
    logic [PHASE_BITS-1:0]  phase_reg, phase_next;

    // entry state
    logic [CACHE_ENTRIES-1:0] valid_reg, valid_next;

    // scan
    logic [CW-1:0]          cnt_reg, cnt_next;
    logic                   chk_vld_reg, chk_vld_next;
    logic [IW-1:0]          chk_idx_reg, chk_idx_next;
    logic                   first_found_reg, first_found_next;
    logic [IW-1:0]          first_idx_reg, first_idx_next;
    logic                   free_found_reg, free_found_next;
    logic [IW-1:0]          free_idx_reg, free_idx_next;
    logic [TICK_BITS-1:0]   oldest_reg, oldest_next;
    logic [IW-1:0]          pick_idx_reg, pick_idx_next;
    logic [ADDR_BITS-1:0]   hit_addr_reg, hit_addr_next;

    // response
    status_t                status_reg, status_next;
    logic [SLOT_BITS-1:0]   slot_reg, slot_next;
    logic [ADDR_BITS-1:0]   found_reg, found_next;

    // memory port
    logic                   rd_en;
    logic [IW-1:0]          rd_idx;
    logic [EW-1:0]          rd_data;
    logic                   wr_en;
    logic [IW-1:0]          wr_idx;
    logic [EW-1:0]          wr_data;

    // checked entry
    logic [KEY_BITS-1:0]    e_key;
    logic [ADDR_BITS-1:0]   e_addr;
    logic [TTL_BITS-1:0]    e_life;
    logic [TICK_BITS-1:0]   e_stamp;
    logic [TICK_BITS-1:0]   e_age;
    logic                   e_valid;
    logic                   e_match;
    logic                   e_expired;
    logic                   scan_last;

    tco_ram #(
        .WIDTH (EW),
        .DEPTH (CACHE_ENTRIES)
    ) u_entries (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_idx),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_idx),
        .rd_data (rd_data)
    );

    assign e_stamp   = rd_data[TICK_BITS-1:0];
    assign e_life    = rd_data[LIFE_LO +: TTL_BITS];
    assign e_addr    = rd_data[ADDR_LO +: ADDR_BITS];
    assign e_key     = rd_data[KEY_LO +: KEY_BITS];
    assign e_valid   = valid_reg[chk_idx_reg];
    assign e_match   = e_valid && (e_key == key_reg);
    assign e_age     = tick_reg - e_stamp;
    assign e_expired = (e_age >= e_life);

    assign scan_last = (cnt_reg == CW'(CACHE_ENTRIES));

    assign stat.kind      = kind_reg;
    assign stat.clean_due = (kind_reg == KIND_TICK) && (phase_reg == '0);
    assign stat.scan_last = scan_last;

    // insert target: matching key, else first free slot, else oldest stamp
    assign wr_idx  = first_found_reg ? first_idx_reg :
                     (free_found_reg ? free_idx_reg : pick_idx_reg);
    assign wr_data = {key_reg, ip_reg, ttl_reg, tick_reg};
    assign wr_en   = cmd.write;
    assign rd_idx  = cnt_reg[IW-1:0];

    assign rsp_status        = status_reg;
    assign rsp_slot          = slot_reg;
    assign rsp_found_address = found_reg;

    always_comb
    begin
        kind_next        = kind_reg;
        key_next         = key_reg;
        ip_next          = ip_reg;
        ttl_next         = ttl_reg;
        tick_next        = tick_reg;
        phase_next       = phase_reg;
        valid_next       = valid_reg;
        cnt_next         = cnt_reg;
        chk_vld_next     = chk_vld_reg;
        chk_idx_next     = chk_idx_reg;
        first_found_next = first_found_reg;
        first_idx_next   = first_idx_reg;
        free_found_next  = free_found_reg;
        free_idx_next    = free_idx_reg;
        oldest_next      = oldest_reg;
        pick_idx_next    = pick_idx_reg;
        hit_addr_next    = hit_addr_reg;
        status_next      = status_reg;
        slot_next        = slot_reg;
        found_next       = found_reg;
        rd_en            = 1'b0;

        // latch request, advance timer and its phase modulo the sweep period
        if (cmd.capture)
        begin
            kind_next        = req_kind;
            key_next         = req_name_key[KEY_BITS-1:0];
            ip_next          = req_ip_address;
            ttl_next         = req_ttl;
            cnt_next         = '0;
            chk_vld_next     = 1'b0;
            first_found_next = 1'b0;
            free_found_next  = 1'b0;
            oldest_next      = tick_reg;
            pick_idx_next    = '0;
            if (req_kind == KIND_TICK)
            begin
                tick_next = tick_reg + 1'b1;
                if (tick_reg == '1 || phase_reg == PHASE_BITS'(CLEAN_PERIOD - 1))
                begin
                    phase_next = '0;
                end
                else
                begin
                    phase_next = phase_reg + 1'b1;
                end
            end
        end

        // scan: issue reads one entry a cycle, check each one in the cycle after its read
        if (cmd.scan_run)
        begin
            if (!scan_last)
            begin
                rd_en        = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                chk_vld_next = 1'b1;
                chk_idx_next = cnt_reg[IW-1:0];
            end
            else
            begin
                chk_vld_next = 1'b0;
            end
            if (chk_vld_reg)
            begin
                case (kind_reg)
                    KIND_INSERT:
                    begin
                        if (e_match && !first_found_reg)
                        begin
                            first_found_next = 1'b1;
                            first_idx_next   = chk_idx_reg;
                        end
                        if (!e_valid && !free_found_reg)
                        begin
                            free_found_next = 1'b1;
                            free_idx_next   = chk_idx_reg;
                        end
                        if (e_valid && (e_stamp < oldest_reg))
                        begin
                            oldest_next   = e_stamp;
                            pick_idx_next = chk_idx_reg;
                        end
                    end
                    KIND_LOOKUP:
                    begin
                        // first live match hits; expired matches before it drop
                        if (e_match && !first_found_reg)
                        begin
                            if (!e_expired)
                            begin
                                first_found_next = 1'b1;
                                first_idx_next   = chk_idx_reg;
                                hit_addr_next    = e_addr;
                            end
                            else
                            begin
                                valid_next[chk_idx_reg] = 1'b0;
                            end
                        end
                    end
                    KIND_TICK:
                    begin
                        if (e_valid && e_expired)
                        begin
                            valid_next[chk_idx_reg] = 1'b0;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
        end

        if (cmd.write)
        begin
            valid_next[wr_idx] = 1'b1;
        end

        // response
        if (cmd.load_rsp)
        begin
            status_next = ST_TICK;
            slot_next   = '0;
            found_next  = '0;
            case (kind_reg)
                KIND_INSERT:
                begin
                    status_next = ST_STORED;
                    slot_next   = SLOT_BITS'(wr_idx);
                end
                KIND_LOOKUP:
                begin
                    if (first_found_reg)
                    begin
                        status_next = ST_HIT;
                        slot_next   = SLOT_BITS'(first_idx_reg);
                        found_next  = hit_addr_reg;
                    end
                    else
                    begin
                        status_next = ST_MISS;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg        <= KIND_TICK;
            tick_reg        <= '0;
            phase_reg       <= '0;
            valid_reg       <= '0;
            cnt_reg         <= '0;
            chk_vld_reg     <= 1'b0;
            first_found_reg <= 1'b0;
            free_found_reg  <= 1'b0;
        end
        else
        begin
            kind_reg        <= kind_next;
            tick_reg        <= tick_next;
            phase_reg       <= phase_next;
            valid_reg       <= valid_next;
            cnt_reg         <= cnt_next;
            chk_vld_reg     <= chk_vld_next;
            first_found_reg <= first_found_next;
            free_found_reg  <= free_found_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        key_reg       <= key_next;
        ip_reg        <= ip_next;
        ttl_reg       <= ttl_next;
        chk_idx_reg   <= chk_idx_next;
        first_idx_reg <= first_idx_next;
        free_idx_reg  <= free_idx_next;
        oldest_reg    <= oldest_next;
        pick_idx_reg  <= pick_idx_next;
        hit_addr_reg  <= hit_addr_next;
        status_reg    <= status_next;
        slot_reg      <= slot_next;
        found_reg     <= found_next;
    end

    a_write_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.write |=> valid_reg[$past(wr_idx)])
        else $error("inserted entry not marked valid");

    a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg < PHASE_BITS'(CLEAN_PERIOD))
        else $error("sweep phase out of range");

    a_tick_advance: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture && (req_kind == KIND_TICK) |=> tick_reg == $past(tick_reg) + 1'b1)
        else $error("tick did not advance the timer");

endmodule

`default_nettype wire

// ===== src/ttl_cache_oldest_replace.sv =====
`default_nettype none

// Channel | Dir | Payload                               | Handshake
// req     | in  | kind, name_key, ip_address, ttl       | valid/ready
// rsp     | out | status, slot, found_address           | valid/ready
//
// One request at a time, one response per request. An insert passes from
// idle through decode, the entry scan and the write to the final state,
// which loads the response; lookup and a sweeping tick skip the write, and
// a plain tick or unused kind skips the scan too. The port reopens in the
// cycle after the load; the scan reads one entry of the RAM per cycle.
// Reset is asynchronous, active low, and clears all valid bits and the timer.
// A stalled response waits in its register; the next request is accepted
// meanwhile and held in the final state until the register frees.
module ttl_cache_oldest_replace #(
    parameter int CACHE_ENTRIES = 16,
    parameter int KEY_BITS      = 64
) (
    input  wire logic clk,
    input  wire logic rst_n,
    tco_req_if.sink   req,
    tco_rsp_if.source rsp
);

    import tco_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    tco_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .cmd       (cmd),
        .stat      (stat)
    );

    tco_dp #(
        .CACHE_ENTRIES (CACHE_ENTRIES),
        .KEY_BITS      (KEY_BITS)
    ) u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .stat              (stat),
        .req_kind          (req.kind),
        .req_name_key      (req.name_key),
        .req_ip_address    (req.ip_address),
        .req_ttl           (req.ttl),
        .rsp_status        (rsp.status),
        .rsp_slot          (rsp.slot),
        .rsp_found_address (rsp.found_address)
    );

endmodule

`default_nettype wire

// ===== verif/ttl_cache_oldest_replace_tb.sv =====
`timescale 1ns / 100ps

module ttl_cache_oldest_replace_tb;
    import tco_pkg::*;

    localparam int CACHE_ENTRIES = 16;
    localparam int KEY_BITS      = 64;
    localparam int SWEEP_PERIOD  = 60;
    localparam int RANDOM_REQS   = 1100;
    localparam int KEY_POOL      = 20;
    localparam int TAIL_CYCLES   = 40;
    localparam int CYCLE_LIMIT   = 600000;
    localparam int MAX_REPORTS   = 50;

    // Kind code with no operation behind it
    localparam kind_t KIND_SPARE = 2'd3;

    typedef struct {
        kind_t       kind;
        logic [63:0] name_key;
        logic [31:0] ip_address;
        logic [31:0] ttl;
        bit          drain_first;   // hold off until all responses are back
    } cache_req_t;

    typedef struct {
        status_t     status;
        logic [7:0]  slot;
        logic [31:0] found_address;
    } cache_rsp_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    tco_req_if req_ch ();
    tco_rsp_if rsp_ch ();

    ttl_cache_oldest_replace #(
        .CACHE_ENTRIES (CACHE_ENTRIES),
        .KEY_BITS      (KEY_BITS)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // Shadow copy of the cache contents
    logic        shadow_valid   [CACHE_ENTRIES];
    logic [63:0] shadow_key     [CACHE_ENTRIES];
    logic [31:0] shadow_address [CACHE_ENTRIES];
    logic [31:0] shadow_life    [CACHE_ENTRIES];
    logic [31:0] shadow_stamp   [CACHE_ENTRIES];
    logic [31:0] shadow_ticks;

    cache_req_t pending_req [$];
    cache_rsp_t expected_rsp [$];
    cache_req_t in_flight;
    logic [63:0] key_pool [KEY_POOL];

    int error_count = 0;
    int cycle_count = 0;
    int gap_left;
    int stall_left;
    bit drv_calm;
    bit mon_calm;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic bit entry_expired(int i);
        logic [31:0] age;
        age = shadow_ticks - shadow_stamp[i];
        return age >= shadow_life[i];
    endfunction

    function automatic void write_entry(int i, logic [63:0] key, logic [31:0] addr,
                                        logic [31:0] life);
        shadow_valid[i]   = 1'b1;
        shadow_key[i]     = key;
        shadow_address[i] = addr;
        shadow_life[i]    = life;
        shadow_stamp[i]   = shadow_ticks;
    endfunction

    // Update the shadow cache with one request, return the response it owes
    function automatic cache_rsp_t apply_request(cache_req_t r);
        cache_rsp_t  rsp;
        logic [63:0] key;
        logic [31:0] oldest;
        int          pick;
        bit          done;
        key = r.name_key & ({64{1'b1}} >> (64 - KEY_BITS));
        rsp.status = ST_TICK;
        rsp.slot = 8'd0;
        rsp.found_address = 32'd0;
        done = 1'b0;
        pick = 0;
        case (r.kind)
            KIND_TICK:
            begin
                shadow_ticks = shadow_ticks + 32'd1;
                if (shadow_ticks % SWEEP_PERIOD == 0) begin
                    for (int i = 0; i < CACHE_ENTRIES; i++)
                        if (shadow_valid[i] && entry_expired(i))
                            shadow_valid[i] = 1'b0;
                end
            end
            KIND_INSERT:
            begin
                // matching key first, then lowest free slot, then oldest stamp
                for (int i = 0; i < CACHE_ENTRIES; i++)
                    if (!done && shadow_valid[i] && shadow_key[i] == key) begin
                        pick = i;
                        done = 1'b1;
                    end
                for (int i = 0; i < CACHE_ENTRIES; i++)
                    if (!done && !shadow_valid[i]) begin
                        pick = i;
                        done = 1'b1;
                    end
                if (!done) begin
                    oldest = shadow_ticks;
                    for (int i = 0; i < CACHE_ENTRIES; i++)
                        if (shadow_stamp[i] < oldest) begin
                            oldest = shadow_stamp[i];
                            pick = i;
                        end
                end
                write_entry(pick, key, r.ip_address, r.ttl);
                rsp.status = ST_STORED;
                rsp.slot = pick[7:0];
            end
            KIND_LOOKUP:
            begin
                // expired matches ahead of a live one get dropped on the way
                rsp.status = ST_MISS;
                for (int i = 0; i < CACHE_ENTRIES; i++)
                    if (!done && shadow_valid[i] && shadow_key[i] == key) begin
                        if (!entry_expired(i)) begin
                            rsp.status = ST_HIT;
                            rsp.slot = i[7:0];
                            rsp.found_address = shadow_address[i];
                            done = 1'b1;
                        end else begin
                            shadow_valid[i] = 1'b0;
                        end
                    end
            end
            default: ;
        endcase
        return rsp;
    endfunction

    // Idle length: mostly none or short, now and then long
    function automatic int draw_pause(bit calm);
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic queue_req(kind_t kind, logic [63:0] key, logic [31:0] addr,
                             logic [31:0] ttl, bit drain);
        cache_req_t r;
        r.kind = kind;
        r.name_key = key;
        r.ip_address = addr;
        r.ttl = ttl;
        r.drain_first = drain;
        pending_req.push_back(r);
    endtask

    // Request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            req_ch.valid <= 1'b0;
            gap_left = 0;
            drv_calm = 1'b0;
        end else begin
            if (req_ch.valid && req_ch.ready)
                expected_rsp.push_back(apply_request(in_flight));
            if (req_ch.valid && !req_ch.ready) begin
                // request still waiting to be taken
            end else if (gap_left > 0) begin
                gap_left--;
                req_ch.valid <= 1'b0;
            end else if (pending_req.size() != 0 &&
                         !(pending_req[0].drain_first && expected_rsp.size() != 0)) begin
                in_flight = pending_req.pop_front();
                req_ch.valid      <= 1'b1;
                req_ch.kind       <= in_flight.kind;
                req_ch.name_key   <= in_flight.name_key;
                req_ch.ip_address <= in_flight.ip_address;
                req_ch.ttl        <= in_flight.ttl;
                if ($urandom_range(0, 49) == 0)
                    drv_calm = !drv_calm;
                gap_left = draw_pause(drv_calm);
            end else begin
                req_ch.valid <= 1'b0;
            end
        end
    end

    // Response monitor and checker
    always @(posedge clk or negedge rst_n)
    begin
        cache_rsp_t want;
        if (!rst_n) begin
            rsp_ch.ready <= 1'b0;
            stall_left = 0;
            mon_calm = 1'b0;
        end else begin
            if (rsp_ch.valid && rsp_ch.ready) begin
                if (expected_rsp.size() == 0) begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                        $display("%0t: response with none expected: status %0d slot %0d addr %h",
                                 $time, rsp_ch.status, rsp_ch.slot, rsp_ch.found_address);
                end else begin
                    want = expected_rsp.pop_front();
                    if (rsp_ch.status !== want.status || rsp_ch.slot !== want.slot ||
                        rsp_ch.found_address !== want.found_address) begin
                        error_count++;
                        if (error_count <= MAX_REPORTS)
                            $display("%0t: mismatch: expected status %0d slot %0d addr %h, got status %0d slot %0d addr %h",
                                     $time, want.status, want.slot, want.found_address,
                                     rsp_ch.status, rsp_ch.slot, rsp_ch.found_address);
                    end
                end
                if ($urandom_range(0, 49) == 0)
                    mon_calm = !mon_calm;
                stall_left = draw_pause(mon_calm);
            end
            if (stall_left > 0) begin
                stall_left--;
                rsp_ch.ready <= 1'b0;
            end else begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL ttl_cache_oldest_replace");
            $finish;
        end
    end

    // Stimulus and end of run
    initial
    begin
        int          r;
        kind_t       kind;
        logic [63:0] key;
        logic [31:0] ttl;
        req_ch.valid = 1'b0;
        req_ch.kind = KIND_TICK;
        req_ch.name_key = 64'd0;
        req_ch.ip_address = 32'd0;
        req_ch.ttl = 32'd0;
        rsp_ch.ready = 1'b0;
        for (int i = 0; i < CACHE_ENTRIES; i++) begin
            shadow_valid[i] = 1'b0;
            shadow_key[i] = 64'd0;
            shadow_address[i] = 32'd0;
            shadow_life[i] = 32'd0;
            shadow_stamp[i] = 32'd0;
        end
        shadow_ticks = 32'd0;

        // Directed: empty miss, extremes, zero lifetime, update, spare kind, full cache
        queue_req(KIND_LOOKUP, 64'h0123_4567_89AB_CDEF, 32'd0, 32'd0, 1'b0);
        queue_req(KIND_INSERT, 64'h0123_4567_89AB_CDEF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        queue_req(KIND_INSERT, 64'd0, 32'd0, 32'd0, 1'b0);
        queue_req(KIND_LOOKUP, 64'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        queue_req(KIND_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0102_0304, 32'd5, 1'b0);
        queue_req(KIND_LOOKUP, 64'h0123_4567_89AB_CDEF, 32'd0, 32'd0, 1'b0);
        queue_req(KIND_INSERT, 64'h0123_4567_89AB_CDEF, 32'hC0A8_0001, 32'd100, 1'b0);
        queue_req(KIND_TICK, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        queue_req(KIND_TICK, 64'd0, 32'd0, 32'd0, 1'b0);
        queue_req(KIND_SPARE, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        for (int i = 2; i < CACHE_ENTRIES; i++)
            queue_req(KIND_INSERT, 64'hA5A5_0000_0000_0000 + i, $urandom, 32'd1000, 1'b0);
        queue_req(KIND_INSERT, 64'h5A5A_5A5A_5A5A_5A5A, 32'h0A00_0001, 32'd1000, 1'b0);
        queue_req(KIND_LOOKUP, 64'h5A5A_5A5A_5A5A_5A5A, 32'd0, 32'd0, 1'b0);

        // Random: keys mostly from a small pool so updates, hits and evictions happen
        for (int i = 0; i < KEY_POOL; i++)
            key_pool[i] = {$urandom, $urandom};
        for (int n = 0; n < RANDOM_REQS; n++) begin
            r = $urandom_range(0, 99);
            if (r < 45)
                kind = KIND_TICK;
            else if (r < 72)
                kind = KIND_INSERT;
            else if (r < 97)
                kind = KIND_LOOKUP;
            else
                kind = KIND_SPARE;
            if ($urandom_range(0, 99) < 12)
                key = {$urandom, $urandom};
            else
                key = key_pool[$urandom_range(0, KEY_POOL - 1)];
            r = $urandom_range(0, 99);
            if (r < 10)
                ttl = 32'd0;
            else if (r < 15)
                ttl = 32'hFFFF_FFFF;
            else if (r < 22)
                ttl = $urandom;
            else
                ttl = $urandom_range(1, 180);
            queue_req(kind, key, $urandom, ttl, (n == 0) || (n == RANDOM_REQS / 2));
        end

        @(posedge rst_n);
        while (pending_req.size() != 0 || req_ch.valid || expected_rsp.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("PASS ttl_cache_oldest_replace");
        else
            $display("FAIL ttl_cache_oldest_replace");
        $finish;
    end

    // Reset held asserted from the start of the run, then released
    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
    end

endmodule
